FILE: hw/rtl/arm_data_processing_execute_unit_defines.svh
// Assertion macros shared by the data-processing execute unit RTL.
// No dependencies; the asserting module pulls this in with an include.
`ifndef ARM_DATA_PROCESSING_EXECUTE_UNIT_DEFINES_SVH
`define ARM_DATA_PROCESSING_EXECUTE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define ADPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define ADPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ADPE_ASSERT(lbl, prop, msg)
`define ADPE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/arm_dp_pkg.sv
// Types, codes and helper functions for the data-processing execute unit.
// No dependencies.
package arm_dp_pkg;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
    OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
    OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
    OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
  } op_e;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,  COND_NE = 4'd1,  COND_CS = 4'd2,  COND_CC = 4'd3,
    COND_MI = 4'd4,  COND_PL = 4'd5,  COND_VS = 4'd6,  COND_VC = 4'd7,
    COND_HI = 4'd8,  COND_LS = 4'd9,  COND_GE = 4'd10, COND_LT = 4'd11,
    COND_GT = 4'd12, COND_LE = 4'd13, COND_AL = 4'd14, COND_NV = 4'd15
  } cond_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
  } shift_e;

  typedef enum logic {
    ACT_EXEC = 1'b0,
    ACT_LOAD = 1'b1
  } action_e;

  // flag bit positions in the 4-bit flag word
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

  // item held in the execute stage
  typedef struct packed {
    action_e     action;
    logic [31:0] ins;
    logic [3:0]  load_index;
    logic [31:0] load_value;
  } stage_t;

  // registered register file read data
  typedef struct packed {
    logic [31:0] rn;
    logic [31:0] rm;
    logic [7:0]  rs;
  } rd_t;

  // register file write port
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    logic [31:0] data;
  } wr_t;

  // one result item
  typedef struct packed {
    logic        executed;
    logic        dest_written;
    logic [3:0]  dest_index;
    logic [31:0] alu_result;
    logic [3:0]  flags_now;
  } res_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] t;
    t = {v, v} >> n;
    return t[31:0];
  endfunction

  function automatic logic cond_pass(input logic [3:0] code, input logic [3:0] f);
    logic n, z, c, v, p;
    n = f[FlagN];
    z = f[FlagZ];
    c = f[FlagC];
    v = f[FlagV];
    unique case (cond_e'(code))
      COND_EQ: p = z;
      COND_NE: p = !z;
      COND_CS: p = c;
      COND_CC: p = !c;
      COND_MI: p = n;
      COND_PL: p = !n;
      COND_VS: p = v;
      COND_VC: p = !v;
      COND_HI: p = c && !z;
      COND_LS: p = !c || z;
      COND_GE: p = (n == v);
      COND_LT: p = (n != v);
      COND_GT: p = !z && (n == v);
      COND_LE: p = z || (n != v);
      COND_AL: p = 1'b1;
      default: p = 1'b0;
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/arm_dp_regfile.sv
// 16 x 32 register file, two copies for three registered read ports.
// Depends on arm_dp_pkg. Reads bypass a write landing on the same edge.
module arm_dp_regfile (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [3:0]        rn_idx_i,
  input  logic [3:0]        rm_idx_i,
  input  logic [3:0]        rs_idx_i,
  input  arm_dp_pkg::wr_t   wr_i,
  output arm_dp_pkg::rd_t   rdata_o
);

  logic [31:0] mem_a_q [16];
  logic [31:0] mem_b_q [16];
  logic [15:0] vld_q;

  logic [31:0] rn_raw_q, rm_raw_q, rs_raw_q;
  logic        rn_byp_q, rm_byp_q, rs_byp_q;
  logic        rn_zero_q, rm_zero_q, rs_zero_q;
  logic [31:0] byp_data_q;

  // entry written since reset; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.idx] <= 1'b1;
    end
  end

  // storage write and registered reads (copy a: rn, rm; copy b: rs)
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_a_q[wr_i.idx] <= wr_i.data;
      mem_b_q[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rn_raw_q <= mem_a_q[rn_idx_i];
      rm_raw_q <= mem_a_q[rm_idx_i];
      rs_raw_q <= mem_b_q[rs_idx_i];
    end
  end

  // read selects: bypass the concurrent write, else zero for unwritten entries
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rn_byp_q   <= wr_i.en && (wr_i.idx == rn_idx_i);
      rm_byp_q   <= wr_i.en && (wr_i.idx == rm_idx_i);
      rs_byp_q   <= wr_i.en && (wr_i.idx == rs_idx_i);
      rn_zero_q  <= !vld_q[rn_idx_i];
      rm_zero_q  <= !vld_q[rm_idx_i];
      rs_zero_q  <= !vld_q[rs_idx_i];
      byp_data_q <= wr_i.data;
    end
  end

  always_comb begin
    rdata_o.rn = rn_byp_q ? byp_data_q : (rn_zero_q ? '0 : rn_raw_q);
    rdata_o.rm = rm_byp_q ? byp_data_q : (rm_zero_q ? '0 : rm_raw_q);
    rdata_o.rs = rs_byp_q ? byp_data_q[7:0] : (rs_zero_q ? '0 : rs_raw_q[7:0]);
  end

endmodule

FILE: hw/rtl/arm_dp_shifter.sv
// Barrel shifter for operand2: rotated immediate or shifted register.
// Depends on arm_dp_pkg.
module arm_dp_shifter (
  input  logic        imm_i,
  input  logic [11:0] ctl_i,
  input  logic [31:0] rm_i,
  input  logic [7:0]  rs_i,
  input  logic        cin_i,
  output logic [31:0] val_o,
  output logic        carry_o
);

  logic [31:0]        imm_val;
  logic               by_reg;
  logic [7:0]         amt;
  logic [4:0]         a5;
  logic               amt_zero, amt_big, amt_32;
  logic [32:0]        lsl33, lsr33, asr33;
  logic [31:0]        ror_v;
  logic [31:0]        sign_fill;

  always_comb begin
    imm_val   = arm_dp_pkg::ror32({24'b0, ctl_i[7:0]}, {ctl_i[11:8], 1'b0});
    by_reg    = ctl_i[4];
    amt       = by_reg ? rs_i : {3'b0, ctl_i[11:7]};
    a5        = amt[4:0];
    amt_zero  = (amt == 8'd0);
    amt_big   = (amt[7:5] != 3'd0);
    amt_32    = (amt == 8'd32);
    // extra bit on the far side catches the last bit shifted out
    lsl33     = {1'b0, rm_i} << a5;
    lsr33     = {rm_i, 1'b0} >> a5;
    asr33     = 33'($signed({rm_i, 1'b0}) >>> a5);
    ror_v     = arm_dp_pkg::ror32(rm_i, a5);
    sign_fill = {32{rm_i[31]}};

    val_o   = rm_i;
    carry_o = cin_i;
    if (imm_i) begin
      val_o   = imm_val;
      carry_o = (ctl_i[11:8] != 4'd0) ? imm_val[31] : cin_i;
    end else begin
      case (arm_dp_pkg::shift_e'(ctl_i[6:5]))
        arm_dp_pkg::SH_LSL: begin
          if (amt_zero) begin
            val_o = rm_i; carry_o = cin_i;
          end else if (amt_big) begin
            val_o = '0; carry_o = amt_32 ? rm_i[0] : 1'b0;
          end else begin
            val_o = lsl33[31:0]; carry_o = lsl33[32];
          end
        end
        arm_dp_pkg::SH_LSR: begin
          if (amt_zero) begin
            // constant zero encodes a shift by 32
            val_o   = by_reg ? rm_i : '0;
            carry_o = by_reg ? cin_i : rm_i[31];
          end else if (amt_big) begin
            val_o = '0; carry_o = amt_32 ? rm_i[31] : 1'b0;
          end else begin
            val_o = lsr33[32:1]; carry_o = lsr33[0];
          end
        end
        arm_dp_pkg::SH_ASR: begin
          if (amt_zero) begin
            val_o   = by_reg ? rm_i : sign_fill;
            carry_o = by_reg ? cin_i : rm_i[31];
          end else if (amt_big) begin
            val_o = sign_fill; carry_o = rm_i[31];
          end else begin
            val_o = asr33[32:1]; carry_o = asr33[0];
          end
        end
        default: begin
          if (amt_zero) begin
            // constant zero is rotate right extended through carry
            val_o   = by_reg ? rm_i : {cin_i, rm_i[31:1]};
            carry_o = by_reg ? cin_i : rm_i[0];
          end else begin
            val_o = ror_v; carry_o = ror_v[31];
          end
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/arm_dp_exec.sv
// Condition check, ALU, flag update and result forming for one item.
// Depends on arm_dp_pkg and arm_dp_shifter.
module arm_dp_exec (
  input  arm_dp_pkg::stage_t stage_i,
  input  arm_dp_pkg::rd_t    rdata_i,
  input  logic [3:0]         flags_i,
  output arm_dp_pkg::res_t   res_o,
  output arm_dp_pkg::wr_t    wr_o,
  output logic [3:0]         flags_o
);

  logic [31:0] ins;
  logic [31:0] op_b;
  logic        sh_carry;
  logic [31:0] x, y, res;
  logic        sub, arith, writes, ok, pass;
  logic [32:0] sum;
  logic        carry;

  assign ins = stage_i.ins;

  arm_dp_shifter u_shifter (
    .imm_i   (ins[25]),
    .ctl_i   (ins[11:0]),
    .rm_i    (rdata_i.rm),
    .rs_i    (rdata_i.rs),
    .cin_i   (flags_i[arm_dp_pkg::FlagC]),
    .val_o   (op_b),
    .carry_o (sh_carry)
  );

  // opcode decode and ALU
  always_comb begin
    x      = rdata_i.rn;
    y      = op_b;
    sub    = 1'b0;
    arith  = 1'b0;
    writes = 1'b1;
    ok     = 1'b1;
    res    = '0;
    case (arm_dp_pkg::op_e'(ins[24:21])) inside
      arm_dp_pkg::OP_SUB, arm_dp_pkg::OP_CMP: begin
        sub = 1'b1; arith = 1'b1;
      end
      arm_dp_pkg::OP_RSB: begin
        x = op_b; y = rdata_i.rn; sub = 1'b1; arith = 1'b1;
      end
      arm_dp_pkg::OP_ADD: arith = 1'b1;
      arm_dp_pkg::OP_AND, arm_dp_pkg::OP_TST: res = rdata_i.rn & op_b;
      arm_dp_pkg::OP_EOR, arm_dp_pkg::OP_TEQ: res = rdata_i.rn ^ op_b;
      arm_dp_pkg::OP_ORR: res = rdata_i.rn | op_b;
      arm_dp_pkg::OP_MOV: res = op_b;
      default: ok = 1'b0;
    endcase
    case (arm_dp_pkg::op_e'(ins[24:21])) inside
      arm_dp_pkg::OP_TST, arm_dp_pkg::OP_TEQ, arm_dp_pkg::OP_CMP: writes = 1'b0;
      default: ;
    endcase
    // shared adder; carry out of x - y is "no borrow"
    sum = {1'b0, x} + {1'b0, y ^ {32{sub}}} + {32'b0, sub};
    if (arith) begin
      res = sum[31:0];
    end
    carry = arith ? sum[32] : sh_carry;
    pass  = arm_dp_pkg::cond_pass(ins[31:28], flags_i);
  end

  // result, write-back and flags
  always_comb begin
    flags_o            = flags_i;
    wr_o.en            = 1'b0;
    wr_o.idx           = ins[15:12];
    wr_o.data          = res;
    res_o.executed     = 1'b0;
    res_o.dest_written = 1'b0;
    res_o.dest_index   = ins[15:12];
    res_o.alu_result   = '0;
    if (stage_i.action == arm_dp_pkg::ACT_LOAD) begin
      wr_o.en            = 1'b1;
      wr_o.idx           = stage_i.load_index;
      wr_o.data          = stage_i.load_value;
      res_o.dest_written = 1'b1;
      res_o.dest_index   = stage_i.load_index;
      res_o.alu_result   = stage_i.load_value;
    end else if (pass && ok) begin
      wr_o.en            = writes;
      res_o.executed     = 1'b1;
      res_o.dest_written = writes;
      res_o.alu_result   = res;
      if (ins[20]) begin
        flags_o[arm_dp_pkg::FlagN] = res[31];
        flags_o[arm_dp_pkg::FlagZ] = (res == 32'd0);
        flags_o[arm_dp_pkg::FlagC] = carry;
      end
    end
    res_o.flags_now = flags_o;
  end

endmodule

FILE: hw/rtl/arm_data_processing_execute_unit.sv
// Data-processing execute unit: ARM ALU with barrel shifter, register file and flags.
// Depends on arm_dp_pkg, arm_dp_regfile, arm_dp_exec and the assertion macro header.
//
// One item per clock while the output is not stalled: an accepted item is
// either a register load or one ARM data-processing instruction (AND, EOR,
// SUB, RSB, ADD, TST, TEQ, CMP, ORR, MOV, others are no-ops). Register
// operands are read at acceptance into registered read ports, the item then
// sits in the execute stage (shifter, adder, flag logic) and its result is
// registered on the output. The register file and flags are updated as the
// result is registered; the next item's operand reads bypass that write, so
// dependent instructions still issue back to back. A stalled output holds
// the execute stage and then the input.
`include "arm_data_processing_execute_unit_defines.svh"

module arm_data_processing_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] instruction_word_i,
  input  logic [3:0]  load_index_i,
  input  logic [31:0] load_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        executed_o,
  output logic        dest_written_o,
  output logic [3:0]  dest_index_o,
  output logic [31:0] alu_result_o,
  output logic [3:0]  flags_now_o
);

  logic                 accept, advance, commit;
  logic                 s1_vld_q, s1_vld_d;
  arm_dp_pkg::stage_t   s1_q;
  arm_dp_pkg::rd_t      rdata;
  arm_dp_pkg::res_t     exec_res;
  arm_dp_pkg::wr_t      exec_wr, wr;
  logic [3:0]           flags_q, flags_d, exec_flags;
  logic                 out_vld_q, out_vld_d;
  arm_dp_pkg::res_t     out_q;

  // handshake: execute stage moves on when the output register is free
  assign advance    = !out_vld_q || !out_stall_i;
  assign commit     = s1_vld_q && advance;
  assign in_stall_o = s1_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  arm_dp_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rn_idx_i (instruction_word_i[19:16]),
    .rm_idx_i (instruction_word_i[3:0]),
    .rs_idx_i (instruction_word_i[11:8]),
    .wr_i     (wr),
    .rdata_o  (rdata)
  );

  arm_dp_exec u_exec (
    .stage_i (s1_q),
    .rdata_i (rdata),
    .flags_i (flags_q),
    .res_o   (exec_res),
    .wr_o    (exec_wr),
    .flags_o (exec_flags)
  );

  // write-back only when the item leaves the execute stage
  always_comb begin
    wr    = exec_wr;
    wr.en = exec_wr.en && commit;
  end

  // execute stage valid, flags and output valid
  always_comb begin
    s1_vld_d  = accept ? 1'b1 : (advance ? 1'b0 : s1_vld_q);
    flags_d   = commit ? exec_flags : flags_q;
    out_vld_d = commit ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      flags_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      flags_q   <= flags_d;
      out_vld_q <= out_vld_d;
    end
  end

  // execute stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.action     <= arm_dp_pkg::action_e'(action_i);
      s1_q.ins        <= instruction_word_i;
      s1_q.load_index <= load_index_i;
      s1_q.load_value <= load_value_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= exec_res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign executed_o     = out_q.executed;
  assign dest_written_o = out_q.dest_written;
  assign dest_index_o   = out_q.dest_index;
  assign alu_result_o   = out_q.alu_result;
  assign flags_now_o    = out_q.flags_now;

  `ADPE_ASSERT(a_stall_needs_item, in_stall_o |-> s1_vld_q, "input stalled with empty stage")
  `ADPE_ASSERT(a_flags_only_on_commit, !commit |=> $stable(flags_q), "flags moved without commit")
  `ADPE_ASSERT(a_commit_fills_output, commit |=> out_vld_q, "committed item lost")
  `ADPE_ASSERT(a_skipped_result_zero,
      out_vld_q && !out_q.executed && !out_q.dest_written |-> out_q.alu_result == 32'd0,
      "skipped instruction with nonzero result")
  `ADPE_ASSERT(a_v_never_set, flags_q[arm_dp_pkg::FlagV] == 1'b0, "V flag set")

endmodule
